@@ hw/rtl/snz_pkg.sv @@
// Shared constants, types and the permutation table of the simplex noise block.
package snz_pkg;

  // Default number of fractional bits of the input coordinates
  localparam int FRAC_BITS_DEF = 16;

  // Dimension codes (code zero is evaluated as 3D)
  localparam logic [1:0] DIM_1D = 2'd1;
  localparam logic [1:0] DIM_2D = 2'd2;
  localparam logic [1:0] DIM_3D = 2'd3;

  // Skew and unskew factors: F in Q0.28, G in Q0.30
  localparam logic [27:0] SKEW_F2 = 28'd98254196;
  localparam logic [27:0] SKEW_F3 = 28'd89478485;
  localparam logic [27:0] UNSK_G2 = 28'd226908346;
  localparam logic [27:0] UNSK_G3 = 28'd178956971;

  // Falloff radii in Q0.30
  localparam logic [30:0] Q_ONE   = 31'h4000_0000;
  localparam logic [30:0] FALL_2D = 31'd536870912;
  localparam logic [30:0] FALL_3D = 31'd644245094;

  // Output scale factors in Q.16
  localparam logic [21:0] SCALE_1D = 22'd25887;
  localparam logic [21:0] SCALE_2D = 22'd2964236;
  localparam logic [21:0] SCALE_3D = 22'd2097152;

  // Saturation limit of the Q1.14 result
  localparam logic [31:0] SAT_LIM = 32'd16384;

  // Corner offset in Q0.30 with headroom, and a gradient dot product
  typedef logic signed [32:0] ofs_t;
  typedef logic signed [35:0] grd_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // Look up the lattice hash
  function automatic logic [7:0] perm(input logic [7:0] a);
    return PERM_ROM[a];
  endfunction

endpackage

@@ hw/rtl/simplex_noise_1d_2d_3d.sv @@
// Simplex gradient noise in 1, 2 or 3 dimensions, thirteen-stage pipeline.
// One noise sample leaves for every coordinate word taken, and a new word can be
// taken in every cycle while the output side is not stalled. The result word is
// registered in turn through stages A to M and is presented from stage M. Each
// stage holds its word until the next stage is free, so bubbles close up and one
// word per cycle flows whenever the output side is ready. The dimension register
// is sampled by the stages as the word passes, so write it only while the
// pipeline is empty.
module simplex_noise_1d_2d_3d #(
  parameter int FRAC_BITS = snz_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x_coord [31:0], y_coord [63:32], z_coord [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // noise_value [15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // dimensions [1:0]
);
  import snz_pkg::*;

  localparam int LB   = FRAC_BITS + 28;
  localparam int NSTG = 13;

  // ---------------------------------------------------------------- config
  logic [1:0] dim_r;
  logic       is1, is2, is3;

  assign cfg_ready = 1'b1;
  assign is1 = (dim_r == DIM_1D);
  assign is2 = (dim_r == DIM_2D);
  assign is3 = !is1 && !is2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_3D;
    end else if (cfg_valid) begin
      dim_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------- stage control
  logic [NSTG-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NSTG-1];

  // ------------------------------------------------------ stage A: skew sum
  logic signed [31:0] a_crd_r [3];
  logic signed [61:0] a_s_r, a_s_nxt;
  logic signed [33:0] a_sum;
  logic signed [28:0] a_f;

  always_comb begin
    a_sum = is3 ? (34'(signed'(in_tdata[31:0])) + 34'(signed'(in_tdata[63:32]))
                   + 34'(signed'(in_tdata[95:64])))
                : (34'(signed'(in_tdata[31:0])) + 34'(signed'(in_tdata[63:32])));
    a_f     = $signed({1'b0, (is3 ? SKEW_F3 : SKEW_F2)});
    a_s_nxt = a_sum * a_f;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_crd_r[0] <= in_tdata[31:0];
      a_crd_r[1] <= in_tdata[63:32];
      a_crd_r[2] <= in_tdata[95:64];
      a_s_r      <= a_s_nxt;
    end
  end

  // --------------------------------------------- stage B: floor and fraction
  logic [7:0]  b_idx_r [3], b_idx_nxt [3];
  logic [29:0] b_frc_r [3], b_frc_nxt [3];
  logic [63:0] b_sk [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      b_sk[c] = {{4{a_crd_r[c][31]}}, a_crd_r[c], 28'd0} + {{2{a_s_r[61]}}, a_s_r};
      b_idx_nxt[c] = b_sk[c][LB+7:LB];
      b_frc_nxt[c] = b_sk[c][LB-1:LB-30];
    end
    // drop the skew in 1D
    if (is1) begin
      b_idx_nxt[0] = a_crd_r[0][FRAC_BITS+7:FRAC_BITS];
      b_frc_nxt[0] = {a_crd_r[0][FRAC_BITS-1:0], {(30-FRAC_BITS){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_idx_r <= b_idx_nxt;
      b_frc_r <= b_frc_nxt;
    end
  end

  // --------------------------------- stage C: unskew product, first hash level
  logic [7:0]  c_idx_r [3];
  logic [29:0] c_frc_r [3];
  logic [29:0] c_d_r, c_d_nxt;
  logic [7:0]  c_l1_r [2], c_l1_nxt [2];
  logic [31:0] c_fsum;
  logic [59:0] c_dp;

  always_comb begin
    c_fsum = 32'(b_frc_r[0]) + 32'(b_frc_r[1]) + (is3 ? 32'(b_frc_r[2]) : 32'd0);
    c_dp   = 60'(c_fsum) * 60'(is3 ? UNSK_G3 : UNSK_G2);
    c_d_nxt = is1 ? 30'd0 : c_dp[59:30];
    c_l1_nxt[0] = perm(b_idx_r[2]);
    c_l1_nxt[1] = perm(b_idx_r[2] + 8'd1);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_idx_r <= b_idx_r;
      c_frc_r <= b_frc_r;
      c_d_r   <= c_d_nxt;
      c_l1_r  <= c_l1_nxt;
    end
  end

  // ----------------------- stage D: first corner offset, corner order, hash 2
  ofs_t       d_o0_r [3], d_o0_nxt [3];
  logic [2:0] d_c1_r, d_c1_nxt, d_c2_r, d_c2_nxt;
  logic [7:0] d_l2_r [4], d_l2_nxt [4];
  logic [7:0] d_i_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_o0_nxt[c] = $signed({3'b0, c_frc_r[c]}) - $signed({3'b0, c_d_r});
    end
    // pick the middle corners (bit 0 = x step, bit 1 = y, bit 2 = z)
    if (is1) begin
      d_c1_nxt = 3'b001;
      d_c2_nxt = 3'b000;
    end else if (is2) begin
      d_c1_nxt = (d_o0_nxt[0] > d_o0_nxt[1]) ? 3'b001 : 3'b010;
      d_c2_nxt = 3'b011;
    end else if (d_o0_nxt[0] >= d_o0_nxt[1]) begin
      if (d_o0_nxt[1] >= d_o0_nxt[2]) begin
        d_c1_nxt = 3'b001; d_c2_nxt = 3'b011;
      end else if (d_o0_nxt[0] >= d_o0_nxt[2]) begin
        d_c1_nxt = 3'b001; d_c2_nxt = 3'b101;
      end else begin
        d_c1_nxt = 3'b100; d_c2_nxt = 3'b101;
      end
    end else begin
      if (d_o0_nxt[1] < d_o0_nxt[2]) begin
        d_c1_nxt = 3'b100; d_c2_nxt = 3'b110;
      end else if (d_o0_nxt[0] < d_o0_nxt[2]) begin
        d_c1_nxt = 3'b010; d_c2_nxt = 3'b110;
      end else begin
        d_c1_nxt = 3'b010; d_c2_nxt = 3'b011;
      end
    end
    // second hash level, indexed by {y step, z step}
    for (int n = 0; n < 4; n++) begin
      d_l2_nxt[n] = perm(c_idx_r[1] + 8'(n >> 1)
                         + (is3 ? c_l1_r[n & 1] : 8'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_o0_r <= d_o0_nxt;
      d_c1_r <= d_c1_nxt;
      d_c2_r <= d_c2_nxt;
      d_l2_r <= d_l2_nxt;
      d_i_r  <= c_idx_r[0];
    end
  end

  // --------------------------------- stage E: all corner offsets and hashes
  ofs_t       e_off_r [4][3], e_off_nxt [4][3];
  logic [7:0] e_h_r [4], e_h_nxt [4];
  logic [2:0] e_bits [4];
  logic [27:0] e_g;
  logic [29:0] e_cg [4];

  always_comb begin
    e_g = is3 ? UNSK_G3 : (is2 ? UNSK_G2 : 28'd0);
    e_bits[0] = 3'b000;
    e_bits[1] = d_c1_r;
    e_bits[2] = d_c2_r;
    e_bits[3] = 3'b111;
    e_cg[0] = 30'd0;
    e_cg[1] = 30'(e_g);
    e_cg[2] = 30'(e_g) << 1;
    e_cg[3] = 30'(e_g) + (30'(e_g) << 1);
    for (int n = 0; n < 4; n++) begin
      for (int a = 0; a < 3; a++) begin
        e_off_nxt[n][a] = d_o0_r[a] - (e_bits[n][a] ? $signed({2'b0, Q_ONE}) : 33'sd0)
                          + $signed({3'b0, e_cg[n]});
        // zero the unused axes
        if ((is1 && a > 0) || (is2 && a == 2)) begin
          e_off_nxt[n][a] = '0;
        end
      end
      e_h_nxt[n] = perm(d_i_r + {7'd0, e_bits[n][0]}
                        + (is1 ? 8'd0 : d_l2_r[{e_bits[n][1], e_bits[n][2]}]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      e_off_r <= e_off_nxt;
      e_h_r   <= e_h_nxt;
    end
  end

  // -------------------------------------------- stage F: squares, gradients
  logic [31:0] f_sq_r [4][3], f_sq_nxt [4][3];
  grd_t        f_gr_r [4], f_gr_nxt [4];
  logic signed [65:0] f_sqp [4][3];

  function automatic grd_t grad_f(input logic d1, input logic d2, input logic [7:0] h,
                                  input ofs_t x, input ofs_t y, input ofs_t z);
    grd_t xs, ys, zs, u, v, r;
    logic [3:0] g;
    xs = {{3{x[32]}}, x};
    ys = {{3{y[32]}}, y};
    zs = {{3{z[32]}}, z};
    g  = {1'b0, h[2:0]} + 4'd1;
    if (d1) begin
      r = $signed({1'b0, g}) * xs;
      if (h[3]) r = -r;
    end else if (d2) begin
      u = (h[5:0] < 6'd4) ? xs : ys;
      v = (h[5:0] < 6'd4) ? ys : xs;
      r = (h[0] ? -u : u) + (h[1] ? -(v <<< 1) : (v <<< 1));
    end else begin
      u = (h[3:0] < 4'd8) ? xs : ys;
      v = (h[3:0] < 4'd4) ? ys : ((h[3:0] == 4'd12 || h[3:0] == 4'd14) ? xs : zs);
      r = (h[0] ? -u : u) + (h[1] ? -v : v);
    end
    return r;
  endfunction

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      for (int a = 0; a < 3; a++) begin
        f_sqp[n][a]    = e_off_r[n][a] * e_off_r[n][a];
        f_sq_nxt[n][a] = f_sqp[n][a][61:30];
      end
      f_gr_nxt[n] = grad_f(is1, is2, e_h_r[n], e_off_r[n][0], e_off_r[n][1], e_off_r[n][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      f_sq_r <= f_sq_nxt;
      f_gr_r <= f_gr_nxt;
    end
  end

  // ------------------------------------------- stage G: falloff, clamp at 0
  logic [30:0] g_t_r [4], g_t_nxt [4];
  grd_t        g_gr_r [4];
  logic signed [35:0] g_t [4];
  logic [30:0] g_fall;
  logic [3:0]  g_act;

  always_comb begin
    g_fall = is1 ? Q_ONE : (is2 ? FALL_2D : FALL_3D);
    g_act  = is1 ? 4'b0011 : (is2 ? 4'b0111 : 4'b1111);
    for (int n = 0; n < 4; n++) begin
      g_t[n] = $signed({5'b0, g_fall}) - $signed({4'b0, f_sq_r[n][0]})
               - $signed({4'b0, f_sq_r[n][1]}) - $signed({4'b0, f_sq_r[n][2]});
      g_t_nxt[n] = (g_t[n] < 0 || !g_act[n]) ? 31'd0 : g_t[n][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      g_t_r  <= g_t_nxt;
      g_gr_r <= f_gr_r;
    end
  end

  // -------------------------------------------- stages H and I: fourth power
  logic [30:0] h_t2_r [4], h_t2_nxt [4], i_t4_r [4], i_t4_nxt [4];
  grd_t        h_gr_r [4], i_gr_r [4];
  logic [61:0] h_p [4], i_p [4];

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      h_p[n]      = 62'(g_t_r[n]) * 62'(g_t_r[n]);
      h_t2_nxt[n] = h_p[n][60:30];
      i_p[n]      = 62'(h_t2_r[n]) * 62'(h_t2_r[n]);
      i_t4_nxt[n] = i_p[n][60:30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      h_t2_r <= h_t2_nxt;
      h_gr_r <= g_gr_r;
    end
    if (adv[8]) begin
      i_t4_r <= i_t4_nxt;
      i_gr_r <= h_gr_r;
    end
  end

  // ------------------------------- stage J: corner contribution, toward zero
  logic signed [37:0] j_n_r [4], j_n_nxt [4];
  logic [35:0] j_mag [4];
  logic [66:0] j_pr [4];

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      j_mag[n]   = i_gr_r[n][35] ? 36'(-i_gr_r[n]) : 36'(i_gr_r[n]);
      j_pr[n]    = 67'(i_t4_r[n]) * 67'(j_mag[n]);
      j_n_nxt[n] = i_gr_r[n][35] ? -$signed({1'b0, j_pr[n][66:30]})
                                 : $signed({1'b0, j_pr[n][66:30]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      j_n_r <= j_n_nxt;
    end
  end

  // ---------------------------------------------------- stage K: corner sum
  logic signed [39:0] k_sum_r, k_sum_nxt;

  assign k_sum_nxt = 40'(j_n_r[0]) + 40'(j_n_r[1]) + 40'(j_n_r[2]) + 40'(j_n_r[3]);

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      k_sum_r <= k_sum_nxt;
    end
  end

  // --------------------------------------------------------- stage L: scale
  logic signed [62:0] l_p_r, l_p_nxt;
  logic signed [22:0] l_sc;

  always_comb begin
    l_sc    = $signed({1'b0, (is1 ? SCALE_1D : (is2 ? SCALE_2D : SCALE_3D))});
    l_p_nxt = k_sum_r * l_sc;
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      l_p_r <= l_p_nxt;
    end
  end

  // ------------------------------------------- stage M: round and saturate
  logic [15:0] m_val_r, m_val_nxt;
  logic [62:0] m_mag;
  logic [63:0] m_rnd;
  logic [31:0] m_q;
  logic [15:0] m_sat;

  always_comb begin
    m_mag = l_p_r[62] ? 63'(-l_p_r) : 63'(l_p_r);
    m_rnd = {1'b0, m_mag} + 64'h0000_0000_8000_0000;
    m_q   = m_rnd[63:32];
    m_sat = (m_q > SAT_LIM) ? SAT_LIM[15:0] : m_q[15:0];
    m_val_nxt = l_p_r[62] ? (16'd0 - m_sat) : m_sat;
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      m_val_r <= m_val_nxt;
    end
  end

  assign out_tdata = m_val_r;

endmodule

@@ hw/rtl/snz_check.sv @@
// Port-level checks of the simplex noise block, bound to its top level.
module snz_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word dropped or changed");

  // keep every result inside plus or minus one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 16'sd16384 && $signed(out_tdata) >= -16'sd16384))
    else $error("noise value out of range");

  // empty the pipeline on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // never refuse a word while the output side is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with the output free");

endmodule

bind simplex_noise_1d_2d_3d snz_check u_snz_check (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench of the simplex noise block: directed and random coordinate words.
`timescale 1ns / 1ps

module tb_top;
  import snz_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // x_coord [31:0], y_coord [63:32], z_coord [95:64]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // noise_value [15:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;   // dimensions [1:0]

  logic [1:0]  model_dims;
  logic [15:0] noise_fifo[$];
  int          error_cnt;
  int          word_cnt;
  int          result_cnt;
  int          cycle_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;

  simplex_noise_1d_2d_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Free-running clock, 8 ns period
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // ---------------- noise predictor ----------------
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint F2 = 98254196;
  localparam longint F3 = 89478485;
  localparam longint G2 = 226908346;
  localparam longint G3 = 178956971;
  localparam longint RAD_2D = 536870912;
  localparam longint RAD_3D = 644245094;

  function automatic int hash8(int a);
    return PERM_ROM[a & 8'hFF];
  endfunction

  // Product shifted right, truncated toward zero
  function automatic longint mul_trunc(longint a, longint b, int sh);
    longint p;
    p = a * b;
    if (p < 0) return -((-p) >> sh);
    return p >> sh;
  endfunction

  function automatic longint sq30(longint a);
    return mul_trunc(a, a, 30);
  endfunction

  function automatic longint falloff4(longint t, bit clamp);
    longint t2;
    if (clamp && t < 0) return 0;
    t2 = mul_trunc(t, t, 30);
    return mul_trunc(t2, t2, 30);
  endfunction

  function automatic longint grad_1d(int h, longint x);
    int k;
    longint g;
    k = h & 'hF;
    g = 1 + (k & 7);
    if (k & 8) g = -g;
    return g * x;
  endfunction

  function automatic longint grad_2d(int h, longint x, longint y);
    int k;
    longint u, v;
    k = h & 'h3F;
    u = (k < 4) ? x : y;
    v = (k < 4) ? y : x;
    return ((k & 1) ? -u : u) + ((k & 2) ? -2 * v : 2 * v);
  endfunction

  function automatic longint grad_3d(int h, longint x, longint y, longint z);
    int k;
    longint u, v;
    k = h & 'hF;
    u = (k < 8) ? x : y;
    v = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
    return ((k & 1) ? -u : u) + ((k & 2) ? -v : v);
  endfunction

  // Split skewed value into lattice index bits and Q0.30 fraction
  function automatic void lattice_split(longint s, output int idx, output longint frac);
    idx  = int'((s >> (FRAC + 28)) & 'hFF);
    frac = (s & ((64'sd1 << (FRAC + 28)) - 1)) >> (FRAC - 2);
  endfunction

  function automatic longint noise_1d(longint x);
    int     i0;
    longint x0, x1, n;
    i0 = int'((x >> FRAC) & 'hFF);
    x0 = (x & ((64'sd1 << FRAC) - 1)) << (30 - FRAC);
    x1 = x0 - ONE_Q30;
    n  = mul_trunc(falloff4(ONE_Q30 - sq30(x0), 1'b0), grad_1d(hash8(i0), x0), 30);
    n += mul_trunc(falloff4(ONE_Q30 - sq30(x1), 1'b0), grad_1d(hash8(i0 + 1), x1), 30);
    return n;
  endfunction

  function automatic longint corner_2d(int h, longint x, longint y);
    return mul_trunc(falloff4(RAD_2D - sq30(x) - sq30(y), 1'b1), grad_2d(h, x, y), 30);
  endfunction

  function automatic longint noise_2d(longint x, longint y);
    longint s, fx, fy, x0, y0, n;
    int     i, j, i1, j1;
    s = (x + y) * F2;
    lattice_split(x * (64'sd1 << 28) + s, i, fx);
    lattice_split(y * (64'sd1 << 28) + s, j, fy);
    x0 = fx - mul_trunc(fx + fy, G2, 30);
    y0 = fy - mul_trunc(fx + fy, G2, 30);
    if (x0 > y0) begin
      i1 = 1; j1 = 0;
    end else begin
      i1 = 0; j1 = 1;
    end
    n  = corner_2d(hash8(i + hash8(j)), x0, y0);
    n += corner_2d(hash8(i + i1 + hash8(j + j1)), x0 - i1 * ONE_Q30 + G2,
                   y0 - j1 * ONE_Q30 + G2);
    n += corner_2d(hash8(i + 1 + hash8(j + 1)), x0 - ONE_Q30 + 2 * G2, y0 - ONE_Q30 + 2 * G2);
    return n;
  endfunction

  function automatic longint corner_3d(int h, longint x, longint y, longint z);
    return mul_trunc(falloff4(RAD_3D - sq30(x) - sq30(y) - sq30(z), 1'b1),
                     grad_3d(h, x, y, z), 30);
  endfunction

  function automatic longint noise_3d(longint x, longint y, longint z);
    longint s, fx, fy, fz, d, x0, y0, z0, n;
    int     i, j, k, i1, j1, k1, i2, j2, k2;
    s = (x + y + z) * F3;
    lattice_split(x * (64'sd1 << 28) + s, i, fx);
    lattice_split(y * (64'sd1 << 28) + s, j, fy);
    lattice_split(z * (64'sd1 << 28) + s, k, fz);
    d  = mul_trunc(fx + fy + fz, G3, 30);
    x0 = fx - d; y0 = fy - d; z0 = fz - d;
    // Pick the simplex corners by ranking the offsets
    if (x0 >= y0) begin
      if (y0 >= z0)      begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
      else if (x0 >= z0) begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 0; k2 = 1; end
      else               begin i1 = 0; j1 = 0; k1 = 1; i2 = 1; j2 = 0; k2 = 1; end
    end else begin
      if (y0 < z0)       begin i1 = 0; j1 = 0; k1 = 1; i2 = 0; j2 = 1; k2 = 1; end
      else if (x0 < z0)  begin i1 = 0; j1 = 1; k1 = 0; i2 = 0; j2 = 1; k2 = 1; end
      else               begin i1 = 0; j1 = 1; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
    end
    n  = corner_3d(hash8(i + hash8(j + hash8(k))), x0, y0, z0);
    n += corner_3d(hash8(i + i1 + hash8(j + j1 + hash8(k + k1))),
                   x0 - i1 * ONE_Q30 + G3, y0 - j1 * ONE_Q30 + G3, z0 - k1 * ONE_Q30 + G3);
    n += corner_3d(hash8(i + i2 + hash8(j + j2 + hash8(k + k2))),
                   x0 - i2 * ONE_Q30 + 2 * G3, y0 - j2 * ONE_Q30 + 2 * G3,
                   z0 - k2 * ONE_Q30 + 2 * G3);
    n += corner_3d(hash8(i + 1 + hash8(j + 1 + hash8(k + 1))),
                   x0 - ONE_Q30 + 3 * G3, y0 - ONE_Q30 + 3 * G3, z0 - ONE_Q30 + 3 * G3);
    return n;
  endfunction

  // Scale, round half away from zero and saturate to Q1.14
  function automatic logic [15:0] predict_noise(logic [31:0] xc, logic [31:0] yc,
                                                logic [31:0] zc, logic [1:0] dims);
    longint x, y, z, n, scl, p, mag;
    x = longint'(signed'(xc));
    y = longint'(signed'(yc));
    z = longint'(signed'(zc));
    if (dims == DIM_1D) begin
      n = noise_1d(x); scl = SCALE_1D;
    end else if (dims == DIM_2D) begin
      n = noise_2d(x, y); scl = SCALE_2D;
    end else begin
      n = noise_3d(x, y, z); scl = SCALE_3D;
    end
    p   = n * scl;
    mag = ((p < 0 ? -p : p) + (64'sd1 << 31)) >> 32;
    if (mag > 16384) mag = 16384;
    return p < 0 ? 16'(-mag) : 16'(mag);
  endfunction

  // ---------------- drivers and checker ----------------

  // Timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               noise_fifo.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result word; signals are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_cnt++;
      if (noise_fifo.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result word %h", $time, out_tdata);
      end else begin
        logic [15:0] want;
        want = noise_fifo.pop_front();
        if (out_tdata !== want) begin
          error_cnt++;
          $display("%0t: noise_value expected %0d got %0d", $time,
                   $signed(want), $signed(out_tdata));
        end
      end
    end
  end

  // Send one coordinate word; tvalid stays high afterwards
  task automatic send_coords(logic [31:0] xc, logic [31:0] yc, logic [31:0] zc);
    bit took;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {zc, yc, xc};
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end
    noise_fifo.push_back(predict_noise(xc, yc, zc, model_dims));
    word_cnt++;
  endtask

  // Hold off until every expected result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (noise_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_dims(logic [1:0] d);
    bit took;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    model_dims = d;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 1048576)) - 1048576);   // within +-16 units
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return {16'($urandom_range(255)), 16'($urandom())};
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed();
    logic [1:0] d;
    for (int m = 0; m < 4; m++) begin
      d = 2'(m);
      write_dims(d);
      send_coords(32'h0, 32'h0, 32'h0);
      send_coords(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_coords(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_coords(32'h0001_8000, 32'h0001_8000, 32'h0001_8000);   // ties on the diagonal
      send_coords(32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000);
      send_coords(32'h00FF_C000, 32'h0100_4000, 32'hFFFE_8000);   // index wrap past 255
    end
  endtask

  // Random phase; the next phase or the final drain drops tvalid
  task automatic test_random(int count, logic [1:0] d, int send_pct, int recv_pct,
                             bit pause_mid);
    write_dims(d);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) drain_results();
      send_coords(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_data = DIM_3D;
    model_dims = DIM_3D; error_cnt = 0; word_cnt = 0; result_cnt = 0; cycle_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(70, DIM_1D, 0, 0, 1'b1);
    test_random(70, DIM_2D, 55, 0, 1'b0);
    test_random(70, DIM_3D, 0, 55, 1'b0);
    test_random(70, 2'd0, 10, 10, 1'b0);
    test_random(65, DIM_3D, 0, 0, 1'b0);
    test_random(65, DIM_2D, 55, 0, 1'b0);
    test_random(65, DIM_1D, 0, 55, 1'b0);
    test_random(65, DIM_3D, 10, 10, 1'b0);
    send_idle_pct = 0;
    drain_results();

    $display("Sent %0d coordinate words over 1D, 2D, 3D and code zero, with idle and", word_cnt);
    $display("stall phases; %0d noise words checked, %0d mismatches.", result_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
